@@ design/nrpt_pkg.sv @@
// Package for the NAPOT region protection table.
// Holds field widths, command and status codes, entry layout and shared types.
// Depends on nothing; every other design file imports it.
package nrpt_pkg;

   localparam int CMD_W    = 2;
   localparam int IDX_IN_W = 8;
   localparam int PERM_W   = 8;
   localparam int BASE_W   = 38;
   localparam int SIZE_W   = 40;
   localparam int SUM_W    = 41;
   localparam int NAPOT_W  = 36;
   localparam int MODE_W   = 8;
   localparam int STATUS_W = 2;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_PROGRAM = 2'd0;
   localparam cmd_type CMD_LOCK    = 2'd1;
   localparam cmd_type CMD_CHECK   = 2'd2;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_DENIED  = 2'd1;
   localparam status_type ST_INVALID = 2'd2;

   localparam logic [MODE_W-1:0] MODE_RWX   = 8'h07;
   localparam logic [MODE_W-1:0] MODE_NAPOT = 8'h18;
   localparam logic [MODE_W-1:0] MODE_LOCK  = 8'h80;
   localparam int                MODE_LOCK_BIT = 7;

   localparam logic [SIZE_W-1:0] MIN_SIZE = 40'h10_0000_1000 & 40'h00_0000_1000;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [NAPOT_W-1:0] napot;
   } entry_type;

   typedef struct packed {
      logic      en;
      entry_type data;
   } mem_wr_type;

endpackage

@@ design/nrpt_req_if.sv @@
// Command channel of the NAPOT region protection table.
// Uses the widths and codes of nrpt_pkg.
interface nrpt_req_if import nrpt_pkg::*; ();
   logic                valid;
   logic                ready;
   cmd_type             cmd;
   logic [IDX_IN_W-1:0] entry_index;
   logic [PERM_W-1:0]   perm;
   logic [BASE_W-1:0]   region_base;
   logic [SIZE_W-1:0]   region_size;

   modport source (output valid, cmd, entry_index, perm, region_base, region_size,
                   input ready);
   modport sink   (input valid, cmd, entry_index, perm, region_base, region_size,
                   output ready);
endinterface

@@ design/nrpt_rsp_if.sv @@
// Result channel of the NAPOT region protection table.
// Uses the status type of nrpt_pkg.
interface nrpt_rsp_if import nrpt_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   logic       access_ok;

   modport source (output valid, status, access_ok, input ready);
   modport sink   (input valid, status, access_ok, output ready);
endinterface

@@ design/nrpt_entry_mem.sv @@
// Protection entry memory: one write port, one read port with registered data.
// Per-entry valid bits make unwritten entries read as zero. Uses nrpt_pkg.
module nrpt_entry_mem import nrpt_pkg::*; #(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   input  mem_wr_type       wr,
   input  logic [IDX_W-1:0] wr_addr,
   output entry_type        rd_entry
);

   entry_type          entry_mem_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   entry_type          rd_data_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_mem_ff[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // An entry never written since reset reads as all zeros.
   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ design/nrpt_check.sv @@
// Region decode and span check for a check command.
// Decodes the NAPOT word by its trailing ones, registers the region bounds
// and the permission match, then compares the queried span. Uses nrpt_pkg.
module nrpt_check import nrpt_pkg::*; (
   input  logic              clock,
   input  logic              load,
   input  entry_type         entry,
   input  logic [PERM_W-1:0] perm,
   input  logic [BASE_W-1:0] base,
   input  logic [SUM_W-1:0]  sum,
   output logic              access_ok
);

   logic [NAPOT_W:0]   w_plus;
   logic [NAPOT_W:0]   ones;
   logic [NAPOT_W-1:0] low;
   logic [NAPOT_W:0]   span_m;
   logic [NAPOT_W+1:0] span_bit;
   logic [BASE_W-1:0]  rbase;
   logic [SIZE_W-1:0]  rsize;
   logic [SUM_W-1:0]   rlimit;
   logic               match;

   logic               match_ff;
   logic [BASE_W-1:0]  rbase_ff;
   logic [SUM_W-1:0]   rlimit_ff;

   always_comb begin
      // Mask of the trailing ones of the address word.
      w_plus   = {1'b0, entry.napot} + (NAPOT_W+1)'(1);
      ones     = w_plus ^ {1'b0, entry.napot};
      low      = ones[NAPOT_W:1];
      // One-hot bit at position t+1, giving a region size of 2^(t+3).
      span_m   = {low, 1'b1};
      span_bit = {span_m, 1'b1} ^ {1'b0, span_m};
      rbase    = {entry.napot & ~low, 2'b00};
      rsize    = {span_bit, 2'b00};
      rlimit   = {3'b000, rbase} + {1'b0, rsize};
      match    = ((entry.mode & MODE_RWX) == perm);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         match_ff  <= match;
         rbase_ff  <= rbase;
         rlimit_ff <= rlimit;
      end
   end

   assign access_ok = match_ff && (base >= rbase_ff) && (sum <= rlimit_ff);

endmodule

@@ design/napot_region_protection_table.sv @@
// NAPOT region protection table, top level.
// A result is loaded in S_CHECK after S_READ and waits while rsp_ch stalls.
// A new command is taken only in S_IDLE, after the read, modify and write-back
// sequence on the single read and write port of the entry memory is done.
// Reset: synchronous, active high; all entries read as zero afterwards through
// per-entry valid bits, so no clearing pass is needed. Uses nrpt_pkg.
module napot_region_protection_table import nrpt_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic       clock,
   input  logic       reset,
   nrpt_req_if.sink   req_ch,
   nrpt_rsp_if.source rsp_ch
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;

   logic [1:0]         state_ff;
   logic [1:0]         state_in;

   cmd_type            cmd_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [PERM_W-1:0]  perm_ff;
   logic [BASE_W-1:0]  base_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [NAPOT_W-1:0] napot_new_ff;
   logic               in_range_ff;
   logic               prog_ok_ff;
   status_type         status_ff;
   status_type         status_in;
   logic               is_check_ff;
   logic               is_check_in;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic               rsp_ok_ff;

   logic               req_accept;
   logic               rsp_load;
   logic [SIZE_W-1:0]  size_m1;
   logic               in_range;
   logic               prog_ok;
   entry_type          rd_entry;
   mem_wr_type         mem_wr;
   logic               chk_ok;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign rsp_load     = (state_ff == S_CHECK) && (!rsp_valid_ff || rsp_ch.ready);

   // Argument checks for a program command, done at the transfer.
   always_comb begin
      size_m1  = req_ch.region_size - SIZE_W'(1);
      in_range = ({1'b0, req_ch.entry_index} < (IDX_IN_W+1)'(ENTRIES));
      prog_ok  = (req_ch.region_base[2:0] == 3'b000) &&
                 (req_ch.region_size >= MIN_SIZE) &&
                 ((req_ch.region_size & size_m1) == '0) &&
                 ((req_ch.region_base & size_m1[BASE_W-1:0]) == '0);
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff       <= req_ch.cmd;
         idx_ff       <= req_ch.entry_index[IDX_W-1:0];
         perm_ff      <= req_ch.perm;
         base_ff      <= req_ch.region_base;
         sum_ff       <= {3'b000, req_ch.region_base} + {1'b0, req_ch.region_size};
         napot_new_ff <= req_ch.region_base[BASE_W-1:2] | size_m1[NAPOT_W+2:3];
         in_range_ff  <= in_range;
         prog_ok_ff   <= prog_ok;
      end
   end

   nrpt_entry_mem #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (req_ch.entry_index[IDX_W-1:0]),
      .wr       (mem_wr),
      .wr_addr  (idx_ff),
      .rd_entry (rd_entry)
   );

   // Read data is in hand during S_READ; decide the status and write back.
   always_comb begin
      status_in        = ST_INVALID;
      is_check_in      = 1'b0;
      mem_wr.en        = 1'b0;
      mem_wr.data      = rd_entry;
      if (in_range_ff) begin
         case (cmd_ff)
            CMD_PROGRAM: begin
               if (rd_entry.mode[MODE_LOCK_BIT]) begin
                  status_in = ST_DENIED;
               end else if (!prog_ok_ff) begin
                  status_in = ST_INVALID;
               end else begin
                  status_in              = ST_OK;
                  mem_wr.en              = (state_ff == S_READ);
                  mem_wr.data.mode       = (perm_ff & (MODE_RWX | MODE_LOCK)) | MODE_NAPOT;
                  mem_wr.data.napot      = napot_new_ff;
               end
            end
            CMD_LOCK: begin
               status_in        = ST_OK;
               mem_wr.en        = (state_ff == S_READ);
               mem_wr.data.mode = rd_entry.mode | MODE_LOCK;
            end
            CMD_CHECK: begin
               status_in   = ST_OK;
               is_check_in = 1'b1;
            end
            default: begin
               status_in = ST_INVALID;
            end
         endcase
      end
   end

   nrpt_check u_check (
      .clock     (clock),
      .load      (state_ff == S_READ),
      .entry     (rd_entry),
      .perm      (perm_ff),
      .base      (base_ff),
      .sum       (sum_ff),
      .access_ok (chk_ok)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         status_ff   <= status_in;
         is_check_ff <= is_check_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_ok_ff     <= is_check_ff && chk_ok;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.access_ok = rsp_ok_ff;

`ifndef NO_ASSERTIONS
   a_write_only_valid: assert property (@(posedge clock) disable iff (reset)
      mem_wr.en |-> (state_ff == S_READ) && in_range_ff &&
                    (cmd_ff == CMD_PROGRAM || cmd_ff == CMD_LOCK))
      else $error("entry write outside a valid program or lock command");

   a_no_write_locked: assert property (@(posedge clock) disable iff (reset)
      mem_wr.en && (cmd_ff == CMD_PROGRAM) |-> !rd_entry.mode[MODE_LOCK_BIT])
      else $error("program command wrote a locked entry");

   a_ok_implies_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ok_ff |-> (rsp_status_ff == ST_OK))
      else $error("access granted with a failing status");

   a_accept_timing: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##2 (state_ff == S_CHECK))
      else $error("command did not reach the check step in two cycles");
`endif

endmodule
